// ===== design/grx_pkg.sv =====
package grx_pkg;

  // Width of char_code * glyph_bytes (8-bit code times 6-bit stride).
  localparam int BASE_W = 14;

  localparam int APB_AW = 4;

  localparam logic [1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [1:0] REG_PITCH      = 2'd1;
  localparam logic [1:0] REG_GLYPH_BYTES = 2'd2;

  localparam logic [15:0] PITCH_RESET  = 16'd1024;
  localparam logic [5:0]  GBYTES_RESET = 6'd16;

  localparam logic [7:0] MASK_ALL = 8'hFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified request as it waits between the front and back parts.
  typedef struct packed {
    logic              is_draw;
    logic              ld_ok;
    logic [12:0]       ld_addr;
    logic [7:0]        ld_data;
    logic [BASE_W-1:0] base;
    logic [31:0]       start_addr;
    logic [31:0]       fg;
    logic [31:0]       bg;
    logic              transp;
  } grx_req_t;

endpackage

// ===== design/grx_ram.sv =====
module grx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    // Read data holds until the next read.
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/grx_front.sv =====
module grx_front #(
  parameter int GLYPH_STORE_DEPTH = 8192
) (
  input  logic              in_req_type,
  input  logic [12:0]       in_load_address,
  input  logic [7:0]        in_load_data,
  input  logic [7:0]        in_char_code,
  input  logic [15:0]       in_x_pos,
  input  logic [15:0]       in_y_pos,
  input  logic [31:0]       in_primary_color,
  input  logic [31:0]       in_secondary_color,
  input  logic [31:0]       frame_base,
  input  logic [15:0]       scanline_pitch,
  input  logic [5:0]        glyph_bytes,
  output grx_pkg::grx_req_t req
);
  import grx_pkg::*;

  logic [31:0] y_off;
  logic [31:0] ld_ext;

  assign y_off  = 32'(in_y_pos) * 32'(scanline_pitch);
  assign ld_ext = 32'(in_load_address);

  always_comb begin
    req.is_draw    = in_req_type;
    req.ld_ok      = ld_ext < 32'(GLYPH_STORE_DEPTH);
    req.ld_addr    = in_load_address;
    req.ld_data    = in_load_data;
    req.base       = BASE_W'(14'(in_char_code) * 14'(glyph_bytes));
    req.start_addr = frame_base + 32'(in_x_pos) + y_off;
    req.fg         = in_primary_color;
    req.bg         = in_secondary_color;
    req.transp     = in_secondary_color[31:24] == 8'h00;
  end

endmodule

// ===== design/grx_fifo.sv =====
module grx_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  grx_pkg::grx_req_t push_data,
  input  logic              pop,
  output grx_pkg::grx_req_t head,
  output logic              full,
  output logic              empty
);
  import grx_pkg::*;

  grx_req_t              ent_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     cnt_r;

  assign full  = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/grx_back.sv =====
module grx_back #(
  parameter int GLYPH_STORE_DEPTH = 8192,
  parameter int GLYPH_ROWS        = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  grx_pkg::grx_req_t q_head,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic [15:0]       scanline_pitch,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_row_address,
  output logic [7:0]        out_row_pattern,
  output logic [7:0]        out_write_mask,
  output logic [31:0]       out_fore_color,
  output logic [31:0]       out_back_color,
  output logic              out_last_row
);
  import grx_pkg::*;

  localparam int IW = $clog2(GLYPH_STORE_DEPTH);
  localparam int XW = ((BASE_W > IW) ? BASE_W : IW) + 1;
  localparam int RW = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(GLYPH_STORE_DEPTH);
  localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_ROWS - 1);

  typedef enum logic {ST_IDLE, ST_ROWS} state_t;

  state_t         state_r, state_nxt;
  logic [XW-1:0]  idx_r, idx_nxt;
  logic [31:0]    addr_r, addr_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [31:0]    fg_r, fg_nxt;
  logic [31:0]    bg_r, bg_nxt;
  logic           tr_r, tr_nxt;

  logic           p1_v_r, p1_v_nxt;
  logic [31:0]    p1_addr_r, p1_addr_nxt;
  logic           p1_last_r, p1_last_nxt;
  logic [31:0]    p1_fg_r, p1_fg_nxt;
  logic [31:0]    p1_bg_r, p1_bg_nxt;
  logic           p1_tr_r, p1_tr_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_addr_r, out_addr_nxt;
  logic [7:0]     out_pat_r, out_pat_nxt;
  logic [7:0]     out_mask_r, out_mask_nxt;
  logic [31:0]    out_fg_r, out_fg_nxt;
  logic [31:0]    out_bg_r, out_bg_nxt;
  logic           out_last_r, out_last_nxt;

  logic           ram_we;
  logic           ram_re;
  logic [IW-1:0]  ram_addr;
  logic [7:0]     ram_rdata;
  logic [XW-1:0]  ld_ext;
  logic           p1_adv;
  logic           p1_free;

  grx_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (q_head.ld_data),
    .rdata (ram_rdata)
  );

  assign ld_ext  = XW'(q_head.ld_addr);
  // The read stage moves on when the output register is empty or being taken.
  assign p1_adv  = p1_v_r && (!out_valid_r || !out_stall);
  assign p1_free = !p1_v_r || p1_adv;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    addr_nxt  = addr_r;
    row_nxt   = row_r;
    fg_nxt    = fg_r;
    bg_nxt    = bg_r;
    tr_nxt    = tr_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = idx_r[IW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.is_draw) begin
            state_nxt = ST_ROWS;
            idx_nxt   = XW'(q_head.base);
            addr_nxt  = q_head.start_addr;
            row_nxt   = '0;
            fg_nxt    = q_head.fg;
            bg_nxt    = q_head.bg;
            tr_nxt    = q_head.transp;
          end else if (q_head.ld_ok) begin
            ram_we   = 1'b1;
            ram_addr = ld_ext[IW-1:0];
          end
        end
      end
      ST_ROWS: begin
        // An index past the end of the store wraps before it is read.
        if (idx_r >= DEPTH_X) begin
          idx_nxt = idx_r - DEPTH_X;
        end else if (p1_free) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          addr_nxt = addr_r + 32'(scanline_pitch);
          row_nxt  = row_r + 1'b1;
          if (row_r == ROW_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    p1_v_nxt    = ram_re ? 1'b1 : (p1_adv ? 1'b0 : p1_v_r);
    p1_addr_nxt = ram_re ? addr_r : p1_addr_r;
    p1_last_nxt = ram_re ? (row_r == ROW_LAST) : p1_last_r;
    p1_fg_nxt   = ram_re ? fg_r : p1_fg_r;
    p1_bg_nxt   = ram_re ? bg_r : p1_bg_r;
    p1_tr_nxt   = ram_re ? tr_r : p1_tr_r;

    out_valid_nxt = p1_adv ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);
    out_addr_nxt  = p1_adv ? p1_addr_r : out_addr_r;
    out_pat_nxt   = p1_adv ? ram_rdata : out_pat_r;
    out_mask_nxt  = p1_adv ? (p1_tr_r ? ram_rdata : MASK_ALL) : out_mask_r;
    out_fg_nxt    = p1_adv ? p1_fg_r : out_fg_r;
    out_bg_nxt    = p1_adv ? p1_bg_r : out_bg_r;
    out_last_nxt  = p1_adv ? p1_last_r : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p1_v_r      <= p1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    addr_r     <= addr_nxt;
    row_r      <= row_nxt;
    fg_r       <= fg_nxt;
    bg_r       <= bg_nxt;
    tr_r       <= tr_nxt;
    p1_addr_r  <= p1_addr_nxt;
    p1_last_r  <= p1_last_nxt;
    p1_fg_r    <= p1_fg_nxt;
    p1_bg_r    <= p1_bg_nxt;
    p1_tr_r    <= p1_tr_nxt;
    out_addr_r <= out_addr_nxt;
    out_pat_r  <= out_pat_nxt;
    out_mask_r <= out_mask_nxt;
    out_fg_r   <= out_fg_nxt;
    out_bg_r   <= out_bg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_row_address = out_addr_r;
  assign out_row_pattern = out_pat_r;
  assign out_write_mask  = out_mask_r;
  assign out_fore_color  = out_fg_r;
  assign out_back_color  = out_bg_r;
  assign out_last_row    = out_last_r;

  // A stuck read stage must keep the store's read data in place.
  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && out_valid_r && out_stall) |-> !ram_re)
    else $error("store read issued while read stage is stalled");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (idx_r < DEPTH_X))
    else $error("store read with unwrapped index");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROWS) |-> !q_pop)
    else $error("queue popped while a character is in progress");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && row_r == ROW_LAST) |=> (state_r == ST_IDLE && p1_last_r))
    else $error("final row did not end the character");

endmodule

// ===== design/glyph_row_expander.sv =====
// Bitmap font character generator, 8 pixels wide.
// Input channel (in_*): a request with in_req_type 0 writes one byte of the
// glyph store; a request with in_req_type 1 draws one character and yields
// GLYPH_ROWS row results on the out_* channel, the last one flagged by
// out_last_row. A request is taken when in_valid is high and in_stall low.
// Requests pass through a two-entry queue, so the input keeps taking requests
// while the row engine is busy, until the queue fills.
// The first row of a character passes through the queue entry, the index
// register, the store read stage and the output register. A draw holds the
// row engine until its last row is read, with an extra wrap step when the
// glyph wraps past the end of the store. The rate is set by the single port
// of the glyph store, which is read once per row.
// When out_stall is high the current row holds and the row engine pauses;
// nothing is dropped. Reset clears the queue and pipeline and restores
// frame_base 0, scanline_pitch 1024 and glyph_bytes 16; the glyph store is not
// cleared and must be loaded before it is drawn from.
module glyph_row_expander #(
  parameter int GLYPH_STORE_DEPTH = 8192,
  parameter int GLYPH_ROWS        = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [12:0] in_load_address,
  input  logic [7:0]  in_load_data,
  input  logic [7:0]  in_char_code,
  input  logic [15:0] in_x_pos,
  input  logic [15:0] in_y_pos,
  input  logic [31:0] in_primary_color,
  input  logic [31:0] in_secondary_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_row_address,
  output logic [7:0]  out_row_pattern,
  output logic [7:0]  out_write_mask,
  output logic [31:0] out_fore_color,
  output logic [31:0] out_back_color,
  output logic        out_last_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [grx_pkg::APB_AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import grx_pkg::*;

  logic [31:0] frame_base_r;
  logic [15:0] pitch_r;
  logic [5:0]  gbytes_r;
  logic        cfg_wr;
  logic [1:0]  reg_sel;

  grx_req_t    front_req;
  grx_req_t    q_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic        q_push;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      pitch_r      <= PITCH_RESET;
      gbytes_r     <= GBYTES_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FRAME_BASE:  frame_base_r <= pwdata;
        REG_PITCH:       pitch_r      <= pwdata[15:0];
        REG_GLYPH_BYTES: gbytes_r     <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_BASE:  prdata = frame_base_r;
      REG_PITCH:       prdata = 32'(pitch_r);
      REG_GLYPH_BYTES: prdata = 32'(gbytes_r);
      default:         prdata = '0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  grx_front #(
    .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH)
  ) u_front (
    .in_req_type        (in_req_type),
    .in_load_address    (in_load_address),
    .in_load_data       (in_load_data),
    .in_char_code       (in_char_code),
    .in_x_pos           (in_x_pos),
    .in_y_pos           (in_y_pos),
    .in_primary_color   (in_primary_color),
    .in_secondary_color (in_secondary_color),
    .frame_base         (frame_base_r),
    .scanline_pitch     (pitch_r),
    .glyph_bytes        (gbytes_r),
    .req                (front_req)
  );

  grx_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_req),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  grx_back #(
    .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH),
    .GLYPH_ROWS        (GLYPH_ROWS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .scanline_pitch  (pitch_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_address (out_row_address),
    .out_row_pattern (out_row_pattern),
    .out_write_mask  (out_write_mask),
    .out_fore_color  (out_fore_color),
    .out_back_color  (out_back_color),
    .out_last_row    (out_last_row)
  );

endmodule
